/* design/tlb_page_table_translator_unit_assert.svh */
// Assertion macros for the translator top module.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_UNIT_ASSERT_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TPT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("translator check failed");

// Next-cycle implication.
`define TPT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("translator check failed");

`endif

/* design/tpt_pkg.sv */
// Shared constants and types for the address translator.
// No dependencies; used by every module of the block.
package tpt_pkg;

	localparam int ADDR_W           = 16;
	localparam int PAGE_W           = 8;
	localparam int OFFSET_W         = 8;
	localparam int FRAME_W          = 8;
	localparam int CNT_W            = 32;
	localparam int TLB_DEPTH_DEF    = 16;
	localparam int PAGE_COUNT_DEF   = 256;
	localparam int FRAME_COUNT_DEF  = 256;

	// One TLB fill request: page and frame go into the slot under the FIFO pointer.
	typedef struct packed {
		logic               en;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
	} tlb_fill_t;

	// One page table entry as stored and as read back.
	typedef struct packed {
		logic               present;
		logic [FRAME_W-1:0] frame;
	} pt_entry_t;

endpackage

/* design/tlb_page_table_translator_unit.sv */
// Address translator: TLB lookup with demand-paged page table behind it.
// Path: an accepted word is registered into the lookup stage, and its result is registered onto
// the result ports with done high. Throughput: one word per cycle while busy is low; the single
// registered lookup stage and the page table memory with one read and one write port (with
// forwarding) set that figure. Results cannot be stalled.
// Reset: TLB, counters and frame allocator clear at once; the page table is then swept one
// entry a cycle, from entry 0 to PAGE_COUNT-1, during which busy is high and no word is taken.
module tlb_page_table_translator_unit #(
	parameter int TLB_DEPTH   = tpt_pkg::TLB_DEPTH_DEF,
	parameter int PAGE_COUNT  = tpt_pkg::PAGE_COUNT_DEF,
	parameter int FRAME_COUNT = tpt_pkg::FRAME_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tpt_pkg::ADDR_W-1:0]    virt_addr,
	output logic                          done,
	output logic [tpt_pkg::ADDR_W-1:0]    physical_address,
	output logic [tpt_pkg::FRAME_W-1:0]   frame_number,
	output logic                          tlb_hit,
	output logic                          page_fault,
	output logic [tpt_pkg::CNT_W-1:0]     hit_total,
	output logic [tpt_pkg::CNT_W-1:0]     miss_total
);

	`include "tlb_page_table_translator_unit_assert.svh"

	localparam int PW  = $clog2(PAGE_COUNT);
	localparam int FW  = $clog2(FRAME_COUNT);
	localparam int RW  = 16;

	// Input stage: the accepted word and its reduced page index.
	logic                             accept;
	logic [RW-1:0]                    rem;
	logic [PW-1:0]                    page_idx;
	logic                             valid_s1;
	logic [PW-1:0]                    page_s1;
	logic [tpt_pkg::OFFSET_W-1:0]     offset_s1;

	// Lookup results and the decision made on them.
	logic                             tlb_match;
	logic [tpt_pkg::FRAME_W-1:0]      tlb_frame;
	tpt_pkg::pt_entry_t               pt_entry;
	logic                             pt_clearing;
	logic                             miss;
	logic                             fault;
	logic [tpt_pkg::FRAME_W-1:0]      frame;
	tpt_pkg::tlb_fill_t               fill;

	// Allocator and statistics.
	logic [FW-1:0]                    next_frame_q;
	logic [tpt_pkg::CNT_W-1:0]        hit_cnt_q;
	logic [tpt_pkg::CNT_W-1:0]        miss_cnt_q;
	logic [tpt_pkg::CNT_W-1:0]        hit_cnt_d;
	logic [tpt_pkg::CNT_W-1:0]        miss_cnt_d;

	assign busy   = pt_clearing;
	assign accept = start && !busy;

	// The page number is reduced modulo PAGE_COUNT. The quotient of an 8-bit page by a
	// count of at least sixteen is below sixteen, so four restoring steps are enough.
	always_comb begin
		rem = RW'(virt_addr[tpt_pkg::ADDR_W-1:tpt_pkg::OFFSET_W]);
		for (int k = 3; k >= 0; k--) begin
			if (rem >= RW'(PAGE_COUNT << k)) begin
				rem = rem - RW'(PAGE_COUNT << k);
			end
		end
		page_idx = PW'(rem);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_s1   <= page_idx;
			offset_s1 <= virt_addr[tpt_pkg::OFFSET_W-1:0];
		end
	end

	tpt_tlb #(
		.DEPTH (TLB_DEPTH)
	) u_tlb (
		.clk       (clk),
		.arst_n    (arst_n),
		.page      (tpt_pkg::PAGE_W'(page_s1)),
		.hit       (tlb_match),
		.hit_frame (tlb_frame),
		.fill      (fill)
	);

	// The page table is read at the accept edge with the incoming page, so its entry is
	// ready in the lookup cycle; a fault written by the word ahead is forwarded.
	tpt_page_table #(
		.PAGE_COUNT (PAGE_COUNT)
	) u_page_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (page_idx),
		.rd_entry (pt_entry),
		.wr_en    (fault),
		.wr_idx   (page_s1),
		.wr_frame (tpt_pkg::FRAME_W'(next_frame_q)),
		.clearing (pt_clearing)
	);

	// A TLB hit takes the cached frame. A miss goes to the page table, and a page that is
	// not resident takes the next free frame, which the outside agent must then load.
	always_comb begin
		miss  = valid_s1 && !tlb_match;
		fault = miss && !pt_entry.present;
		if (tlb_match) begin
			frame = tlb_frame;
		end else if (pt_entry.present) begin
			frame = pt_entry.frame;
		end else begin
			frame = tpt_pkg::FRAME_W'(next_frame_q);
		end
		fill.en    = miss;
		fill.page  = tpt_pkg::PAGE_W'(page_s1);
		fill.frame = frame;
	end

	always_comb begin
		hit_cnt_d  = hit_cnt_q;
		miss_cnt_d = miss_cnt_q;
		if (valid_s1 && tlb_match && (hit_cnt_q != '1)) begin
			hit_cnt_d = hit_cnt_q + 1'b1;
		end
		if (miss && (miss_cnt_q != '1)) begin
			miss_cnt_d = miss_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_frame_q <= '0;
			hit_cnt_q    <= '0;
			miss_cnt_q   <= '0;
			done         <= 1'b0;
		end else begin
			hit_cnt_q  <= hit_cnt_d;
			miss_cnt_q <= miss_cnt_d;
			done       <= valid_s1;
			if (fault) begin
				next_frame_q <= (next_frame_q == FW'(FRAME_COUNT - 1)) ? '0
					: next_frame_q + 1'b1;
			end
		end
	end

	// Result register: presented for exactly one cycle under done.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			physical_address <= {frame, offset_s1};
			frame_number     <= frame;
			tlb_hit          <= tlb_match;
			page_fault       <= fault;
			hit_total        <= hit_cnt_d;
			miss_total       <= miss_cnt_d;
		end
	end

	// A freshly allocated frame never comes with a TLB hit.
	`TPT_ASSERT_NOW(a_fault_excludes_hit, done, !(tlb_hit && page_fault))
	// No word is in flight while the page table is being swept.
	`TPT_ASSERT_NOW(a_idle_while_clearing, busy, !valid_s1)
	// A miss below saturation advances the miss count by one.
	`TPT_ASSERT_NEXT(a_miss_counts, miss && (miss_cnt_q != '1),
		miss_total == $past(miss_cnt_q) + 1'b1)
	// A hit leaves the miss count where it was.
	`TPT_ASSERT_NEXT(a_hit_keeps_miss, valid_s1 && tlb_match, miss_total == $past(miss_cnt_q))

endmodule

/* design/tpt_tlb.sv */
// Fully associative TLB with FIFO replacement.
// Depends on tpt_pkg for field widths and the fill request type.
module tpt_tlb #(
	parameter int DEPTH = tpt_pkg::TLB_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [tpt_pkg::PAGE_W-1:0]  page,
	output logic                        hit,
	output logic [tpt_pkg::FRAME_W-1:0] hit_frame,
	input  tpt_pkg::tlb_fill_t          fill
);

	localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [tpt_pkg::PAGE_W-1:0]  page_q  [DEPTH];
	logic [tpt_pkg::FRAME_W-1:0] frame_q [DEPTH];
	logic [DEPTH-1:0]            valid_q;
	logic [SW-1:0]               slot_q;

	// Walk from the top so that the lowest matching slot wins.
	always_comb begin
		hit       = 1'b0;
		hit_frame = '0;
		for (int k = DEPTH - 1; k >= 0; k--) begin
			if (valid_q[k] && (page_q[k] == page)) begin
				hit       = 1'b1;
				hit_frame = frame_q[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			slot_q  <= '0;
		end else if (fill.en) begin
			valid_q[slot_q] <= 1'b1;
			slot_q          <= (slot_q == SW'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fill.en) begin
			page_q[slot_q]  <= fill.page;
			frame_q[slot_q] <= fill.frame;
		end
	end

endmodule

/* design/tpt_page_table.sv */
// Page table memory with a clearing pass after reset and write-to-read forwarding.
// Depends on tpt_pkg for the entry type.
module tpt_page_table #(
	parameter int PAGE_COUNT = tpt_pkg::PAGE_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [$clog2(PAGE_COUNT)-1:0]   rd_idx,
	output tpt_pkg::pt_entry_t              rd_entry,
	input  logic                            wr_en,
	input  logic [$clog2(PAGE_COUNT)-1:0]   wr_idx,
	input  logic [tpt_pkg::FRAME_W-1:0]     wr_frame,
	output logic                            clearing
);

	localparam int PW = $clog2(PAGE_COUNT);

	tpt_pkg::pt_entry_t mem [PAGE_COUNT];
	tpt_pkg::pt_entry_t rd_data_q;
	tpt_pkg::pt_entry_t fwd_data_q;
	logic               fwd_q;
	logic               clr_q;
	logic [PW-1:0]      clr_idx_q;
	logic               mem_we;
	logic [PW-1:0]      mem_widx;
	tpt_pkg::pt_entry_t mem_wdata;

	assign clearing = clr_q;

	always_comb begin
		mem_we    = clr_q | wr_en;
		mem_widx  = clr_q ? clr_idx_q : wr_idx;
		mem_wdata = '0;
		if (!clr_q) begin
			mem_wdata.present = 1'b1;
			mem_wdata.frame   = wr_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == PW'(PAGE_COUNT - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_widx] <= mem_wdata;
		end
		rd_data_q  <= mem[rd_idx];
		fwd_data_q <= mem_wdata;
	end

	// A write landing on the same edge as the read of the same entry wins.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= mem_we && (mem_widx == rd_idx);
		end
	end

	assign rd_entry = fwd_q ? fwd_data_q : rd_data_q;

endmodule

/* dv/translation_scoreboard_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the address translator: a cycle-free predictor of the TLB,
// the demand-paged page table and the counters, plus the in-order result check.
// Depends on tpt_pkg for widths and default sizes.
package translation_scoreboard_pkg;

	localparam int TLB_SLOTS  = tpt_pkg::TLB_DEPTH_DEF;
	localparam int PAGE_SLOTS = tpt_pkg::PAGE_COUNT_DEF;
	localparam int FRAME_POOL = tpt_pkg::FRAME_COUNT_DEF;

	typedef struct {
		logic [tpt_pkg::ADDR_W-1:0]  physical_address;
		logic [tpt_pkg::FRAME_W-1:0] frame_number;
		logic                        tlb_hit;
		logic                        page_fault;
		logic [tpt_pkg::CNT_W-1:0]   hit_total;
		logic [tpt_pkg::CNT_W-1:0]   miss_total;
	} translation_t;

	class translation_scoreboard;
		logic [tpt_pkg::PAGE_W-1:0]  tlb_page [TLB_SLOTS];
		logic [tpt_pkg::FRAME_W-1:0] tlb_frame [TLB_SLOTS];
		bit                          tlb_valid [TLB_SLOTS];
		logic [tpt_pkg::FRAME_W-1:0] table_frame [PAGE_SLOTS];
		bit                          table_present [PAGE_SLOTS];
		int unsigned                 free_frame;
		int unsigned                 fill_slot;
		logic [tpt_pkg::CNT_W-1:0]   hits;
		logic [tpt_pkg::CNT_W-1:0]   misses;
		translation_t                pending_translations [$];
		int unsigned                 failures;

		function new();
			for (int i = 0; i < TLB_SLOTS; i++) begin
				tlb_page[i]  = '0;
				tlb_frame[i] = '0;
				tlb_valid[i] = 1'b0;
			end
			for (int i = 0; i < PAGE_SLOTS; i++) begin
				table_frame[i]   = '0;
				table_present[i] = 1'b0;
			end
			free_frame = 0;
			fill_slot  = 0;
			hits       = '0;
			misses     = '0;
			failures   = 0;
		endfunction

		// Translates one address and advances the TLB, page table and counters.
		function translation_t translate(logic [tpt_pkg::ADDR_W-1:0] addr);
			translation_t                r;
			int unsigned                 page;
			logic [tpt_pkg::FRAME_W-1:0] frame;
			bit                          hit;
			bit                          fault;
			page  = addr[tpt_pkg::ADDR_W-1:tpt_pkg::OFFSET_W] % PAGE_SLOTS;
			frame = '0;
			hit   = 1'b0;
			fault = 1'b0;
			for (int k = 0; k < TLB_SLOTS; k++) begin
				if (!hit && tlb_valid[k] && tlb_page[k] == page[tpt_pkg::PAGE_W-1:0]) begin
					frame = tlb_frame[k];
					hit   = 1'b1;
				end
			end
			if (hit) begin
				if (hits != '1)
					hits = hits + 1;
			end else begin
				if (misses != '1)
					misses = misses + 1;
				if (table_present[page]) begin
					frame = table_frame[page];
				end else begin
					frame               = tpt_pkg::FRAME_W'(free_frame % FRAME_POOL);
					table_frame[page]   = frame;
					table_present[page] = 1'b1;
					fault               = 1'b1;
					free_frame          = (free_frame % FRAME_POOL + 1) % FRAME_POOL;
				end
				tlb_page[fill_slot]  = page[tpt_pkg::PAGE_W-1:0];
				tlb_frame[fill_slot] = frame;
				tlb_valid[fill_slot] = 1'b1;
				fill_slot            = (fill_slot + 1) % TLB_SLOTS;
			end
			r.physical_address = {frame, addr[tpt_pkg::OFFSET_W-1:0]};
			r.frame_number     = frame;
			r.tlb_hit          = hit;
			r.page_fault       = fault;
			r.hit_total        = hits;
			r.miss_total       = misses;
			return r;
		endfunction

		function void note_word(logic [tpt_pkg::ADDR_W-1:0] addr);
			pending_translations.push_back(translate(addr));
		endfunction

		function int pending();
			return pending_translations.size();
		endfunction

		function void compare_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				failures++;
			end
		endfunction

		function void check_word(translation_t got);
			translation_t want;
			if (pending_translations.size() == 0) begin
				$error("result word arrived with no translation outstanding");
				failures++;
				return;
			end
			want = pending_translations.pop_front();
			compare_field("physical_address", want.physical_address, got.physical_address);
			compare_field("frame_number", want.frame_number, got.frame_number);
			compare_field("tlb_hit", want.tlb_hit, got.tlb_hit);
			compare_field("page_fault", want.page_fault, got.page_fault);
			compare_field("hit_total", want.hit_total, got.hit_total);
			compare_field("miss_total", want.miss_total, got.miss_total);
		endfunction
	endclass

endpackage

/* dv/tb_tlb_page_table_translator_unit.sv */
`timescale 1ns / 100ps
// Top-level testbench for the address translator: drives address words through
// start/busy and checks every done word against translation_scoreboard_pkg.
// Depends on tpt_pkg, translation_scoreboard_pkg and the translator RTL.
module tb_tlb_page_table_translator_unit;
	import tpt_pkg::*;
	import translation_scoreboard_pkg::*;

	// The watchdog limit sits well above the length of the page table's reset sweep,
	// during which busy is high, and above any sender gap.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int WORDS_PER_PHASE = 600;
	localparam int SETTLE_CYCLES = 8;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [ADDR_W-1:0]  virt_addr = '0;
	logic               busy;
	logic               done;
	logic [ADDR_W-1:0]  physical_address;
	logic [FRAME_W-1:0] frame_number;
	logic               tlb_hit;
	logic               page_fault;
	logic [CNT_W-1:0]   hit_total;
	logic [CNT_W-1:0]   miss_total;

	translation_scoreboard sb = new();

	// Pages touched lately; drawing from the front of this list gives TLB hits,
	// drawing from deeper in it gives misses on pages that are already resident.
	logic [PAGE_W-1:0] recent_pages [$];
	int unsigned       idle_cycles;

	tlb_page_table_translator_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.virt_addr        (virt_addr),
		.done             (done),
		.physical_address (physical_address),
		.frame_number     (frame_number),
		.tlb_hit          (tlb_hit),
		.page_fault       (page_fault),
		.hit_total        (hit_total),
		.miss_total       (miss_total)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Everything is sampled at the rising edge, before the block's flops update.
	// A result word is checked first, then a newly accepted address word is noted.
	always @(posedge clk) begin
		translation_t got;
		if (arst_n && done) begin
			got.physical_address = physical_address;
			got.frame_number     = frame_number;
			got.tlb_hit          = tlb_hit;
			got.page_fault       = page_fault;
			got.hit_total        = hit_total;
			got.miss_total       = miss_total;
			sb.check_word(got);
		end
		if (arst_n && start && !busy)
			sb.note_word(virt_addr);
	end

	// Watchdog: counts cycles in which no word moves in either direction.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial idle_cycles = 0;

	// Offers one address word, idling first with the given chance per cycle, and
	// returns at the edge that accepts it. Start stays high into the next call
	// unless that call decides to idle, so back-to-back words need no gap.
	task automatic send_word(logic [ADDR_W-1:0] addr, int unsigned idle_pct);
		forever begin
			@(negedge clk);
			if ($urandom_range(99) < idle_pct) begin
				start = 1'b0;
			end else begin
				start = 1'b1;
				virt_addr = addr;
				break;
			end
		end
		do
			@(posedge clk);
		while (busy);
	endtask

	// Holds the sender off until every outstanding translation has come back.
	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Picks a random address with locality. Most words reuse a page from the
	// last dozen (TLB hits), some reach further back into the recent list (misses
	// on resident pages, after the FIFO has evicted them), and the rest are fully
	// random addresses that mostly fault until every page is resident.
	function automatic logic [ADDR_W-1:0] pick_address();
		logic [PAGE_W-1:0] page;
		int unsigned       roll;
		int unsigned       depth;
		roll  = $urandom_range(99);
		depth = recent_pages.size();
		if (roll < 65 && depth > 0)
			page = recent_pages[$urandom_range((depth < 12 ? depth : 12) - 1)];
		else if (roll < 85 && depth > 0)
			page = recent_pages[$urandom_range(depth - 1)];
		else
			page = PAGE_W'($urandom_range(255));
		recent_pages.push_front(page);
		if (recent_pages.size() > 48)
			void'(recent_pages.pop_back());
		return {page, 8'($urandom_range(255))};
	endfunction

	initial begin
		int unsigned idle_pct [3];
		idle_pct = '{38, 50, 0};
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed part. Page 0 and page 255 fault and are then hit, each touched at both
		// offset extremes. Sixteen more pages fault, which wraps the fill pointer
		// and evicts pages 0 and 255 from the TLB; revisiting them must miss the
		// TLB yet find the page resident, so no fault and the old frame comes back.
		send_word(16'h0000, 0);
		send_word(16'h00ff, 0);
		send_word(16'hffff, 0);
		send_word(16'hff00, 0);
		for (int p = 1; p <= 16; p++)
			send_word({8'(p), 8'(p * 13)}, 0);
		send_word(16'h00aa, 0);
		send_word(16'hff55, 0);
		send_word(16'h8001, 0);
		send_word(16'h8001, 0);
		drain_results();

		// Random part in three phases of sender idling, with the sender paused
		// until the block has answered everything at the end of each phase.
		foreach (idle_pct[ph]) begin
			for (int n = 0; n < WORDS_PER_PHASE; n++)
				send_word(pick_address(), idle_pct[ph]);
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
